// ===== rtl/rabb_pkg.sv =====
package rabb_pkg;

  // Fixed geometry of the engine.
  localparam int unsigned MaxLine    = 1024;
  localparam int unsigned IndexBits  = 20;
  localparam int unsigned CountBits  = $clog2(MaxLine);
  localparam int unsigned SizeBits   = 11;
  localparam int unsigned ChanBits   = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned SumBits    = 2 * ChanBits;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 20;

  localparam logic [ChanBits-1:0] AlphaOpaque = 8'd255;

  typedef logic [ChanBits-1:0]  chan_t;
  typedef logic [SumBits-1:0]   sum_t;
  typedef logic [IndexBits-1:0] index_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [SizeBits-1:0]  size_t;
  typedef logic [NumChan-1:0][ChanBits-1:0] pixel_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_BLEND_MODE   = 3'd0,
    CFG_REGION_WIDTH = 3'd1,
    CFG_REGION_HEIGHT = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_DEST_START   = 3'd4,
    CFG_BITMAP_WIDTH = 3'd5,
    CFG_SOURCE_START = 3'd6
  } cfg_reg_e;

  // Load enables of the input register and the result register.
  typedef struct packed {
    logic load_in;
    logic load_out;
  } pipe_ctrl_t;

  // Exact floor(x / 255) for any x below 65280.
  function automatic chan_t div255(input sum_t x);
    logic [SumBits:0] t;
    t = {1'b0, x} + {{SumBits{1'b0}}, 1'b1} + {9'b0, x[SumBits-1:ChanBits]};
    return t[SumBits-1:ChanBits];
  endfunction

  // Last column or row position for a size register: 0 acts as 1, saturated at MaxLine.
  function automatic count_t last_pos(input size_t v);
    if (v == '0) begin
      return '0;
    end else if (v > size_t'(MaxLine)) begin
      return count_t'(MaxLine - 1);
    end else begin
      return count_t'(v - size_t'(1));
    end
  endfunction

endpackage

// ===== rtl/rabb_blend.sv =====
module rabb_blend (
  input  logic                clk_i,
  input  rabb_pkg::pipe_ctrl_t ctrl_i,
  input  logic                blend_mode_i,
  input  rabb_pkg::chan_t     alpha_i,
  input  rabb_pkg::pixel_t    src_i,
  input  rabb_pkg::pixel_t    bg_i,
  output rabb_pkg::pixel_t    rgb_o
);
  import rabb_pkg::*;

  logic   mode_q;
  chan_t  alpha_q;
  pixel_t src_q;
  pixel_t bg_q;
  sum_t [NumChan-1:0] sum;
  pixel_t rgb_d;
  pixel_t rgb_q;

  // Input stage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      mode_q  <= blend_mode_i;
      alpha_q <= alpha_i;
      src_q   <= src_i;
      bg_q    <= bg_i;
    end
  end

  // Weighted sum per channel. Copy mode forms src*255 so that the shared
  // divide hands back the source value unchanged.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (mode_q) begin
        sum[c] = sum_t'(alpha_q) * sum_t'(src_q[c])
               + sum_t'(AlphaOpaque - alpha_q) * sum_t'(bg_q[c]);
      end else begin
        sum[c] = {src_q[c], {ChanBits{1'b0}}} - {{ChanBits{1'b0}}, src_q[c]};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rgb_d[c] = div255(sum[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

// ===== rtl/rect_alpha_blend_blit_top.sv =====
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the output is not stalled.
// The weighted sum and the divide by 255 sit in one combinational pass
// between the two registers.
// Reset (rst_ni low, asynchronous) empties the pipeline, returns the row and
// column counters to the top-left corner and sets the registers to their defaults.
module rect_alpha_blend_blit_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [rabb_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [rabb_pkg::CfgBits-1:0]        cfg_data_i,
  // Pixel input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          src_red_i,
  input  logic [7:0]                          src_green_i,
  input  logic [7:0]                          src_blue_i,
  input  logic [7:0]                          src_alpha_i,
  input  logic [7:0]                          bg_red_i,
  input  logic [7:0]                          bg_green_i,
  input  logic [7:0]                          bg_blue_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          out_red_o,
  output logic [7:0]                          out_green_o,
  output logic [7:0]                          out_blue_o,
  output logic [rabb_pkg::IndexBits-1:0]      dest_index_o,
  output logic [rabb_pkg::IndexBits-1:0]      source_index_o,
  output logic                                last_pixel_o
);
  import rabb_pkg::*;

  // Configuration registers. A change takes effect on the next accepted
  // transaction; the start indices are only read on the first pixel.
  logic   blend_mode_q;
  size_t  region_width_q;
  size_t  region_height_q;
  size_t  frame_width_q;
  index_t dest_start_q;
  size_t  bitmap_width_q;
  index_t source_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q    <= 1'b0;
      region_width_q  <= size_t'(1);
      region_height_q <= size_t'(1);
      frame_width_q   <= size_t'(1);
      dest_start_q    <= '0;
      bitmap_width_q  <= size_t'(1);
      source_start_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLEND_MODE:    blend_mode_q    <= cfg_data_i[0];
        CFG_REGION_WIDTH:  region_width_q  <= cfg_data_i[SizeBits-1:0];
        CFG_REGION_HEIGHT: region_height_q <= cfg_data_i[SizeBits-1:0];
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[SizeBits-1:0];
        CFG_DEST_START:    dest_start_q    <= cfg_data_i[IndexBits-1:0];
        CFG_BITMAP_WIDTH:  bitmap_width_q  <= cfg_data_i[SizeBits-1:0];
        CFG_SOURCE_START:  source_start_q  <= cfg_data_i[IndexBits-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage takes a new transaction when it is
  // empty or when the stage after it is taking its current one, so the
  // block keeps accepting while a finished result leaves the output.
  logic v_in_q, v_out_q;
  logic rdy_in, rdy_out;
  logic accept;
  pipe_ctrl_t ctrl;

  assign rdy_out = !v_out_q || !out_stall_i;
  assign rdy_in  = !v_in_q || rdy_out;
  assign accept  = in_valid_i && rdy_in;
  assign in_stall_o = !rdy_in;

  assign ctrl.load_in  = accept;
  assign ctrl.load_out = v_in_q && rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (rdy_in) begin
        v_in_q <= in_valid_i;
      end
      if (rdy_out) begin
        v_out_q <= v_in_q;
      end
    end
  end

  // Raster walk over the rectangle. The counters step once per accepted
  // transaction. A counter at or past the last position (which can happen
  // after a size change mid-rectangle) ends the row or the rectangle.
  count_t col_q, col_d;
  count_t row_q, row_d;
  index_t dest_base_q, dest_base_d;
  index_t source_base_q, source_base_d;
  index_t dest_base_cur, source_base_cur;
  index_t dest_index, source_index;
  logic   first_pixel, row_end, last;

  always_comb begin
    first_pixel     = (col_q == '0) && (row_q == '0);
    dest_base_cur   = first_pixel ? dest_start_q : dest_base_q;
    source_base_cur = first_pixel ? source_start_q : source_base_q;
    row_end         = col_q >= last_pos(region_width_q);
    last            = row_end && (row_q >= last_pos(region_height_q));
    dest_index      = dest_base_cur + index_t'(col_q);
    source_index    = source_base_cur + index_t'(col_q);

    col_d         = col_q + count_t'(1);
    row_d         = row_q;
    dest_base_d   = dest_base_cur;
    source_base_d = source_base_cur;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d         = '0;
      row_d         = row_q + count_t'(1);
      dest_base_d   = dest_base_cur + index_t'(frame_width_q);
      source_base_d = source_base_cur + index_t'(bitmap_width_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      dest_base_q   <= '0;
      source_base_q <= '0;
    end else if (accept) begin
      col_q         <= col_d;
      row_q         <= row_d;
      dest_base_q   <= dest_base_d;
      source_base_q <= source_base_d;
    end
  end

  // The indices and the last flag travel beside the colour data.
  index_t dest_in_q, dest_out_q;
  index_t source_in_q, source_out_q;
  logic   last_in_q, last_out_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load_in) begin
      dest_in_q   <= dest_index;
      source_in_q <= source_index;
      last_in_q   <= last;
    end
    if (ctrl.load_out) begin
      dest_out_q   <= dest_in_q;
      source_out_q <= source_in_q;
      last_out_q   <= last_in_q;
    end
  end

  // Colour datapath: copy or alpha blend, then the exact divide by 255.
  pixel_t src_pix, bg_pix, rgb;

  assign src_pix = {src_blue_i, src_green_i, src_red_i};
  assign bg_pix  = {bg_blue_i, bg_green_i, bg_red_i};

  rabb_blend u_blend (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .blend_mode_i (blend_mode_q),
    .alpha_i      (src_alpha_i),
    .src_i        (src_pix),
    .bg_i         (bg_pix),
    .rgb_o        (rgb)
  );

  assign out_valid_o    = v_out_q;
  assign out_red_o      = rgb[0];
  assign out_green_o    = rgb[1];
  assign out_blue_o     = rgb[2];
  assign dest_index_o   = dest_out_q;
  assign source_index_o = source_out_q;
  assign last_pixel_o   = last_out_q;

endmodule
